FILE: sv/mat_pkg.sv
// Shared types, constants and register indexes for the multi-turn angle tracker.
`timescale 1ns / 1ps
package mat_pkg;

  localparam int AngleW   = 12;
  localparam int QuadW    = 3;
  localparam int TurnCntW = 16;
  localparam int TotalW   = 29;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 12;

  localparam int TurnWidth = 16;
  localparam int WideW = (TurnWidth + AngleW > TotalW) ? TurnWidth + AngleW : TotalW;

  localparam logic signed [TurnWidth-1:0] TurnMax = {1'b0, {(TurnWidth-1){1'b1}}};
  localparam logic signed [TurnWidth-1:0] TurnMin = {1'b1, {(TurnWidth-1){1'b0}}};
  localparam logic signed [TurnWidth-1:0] TurnZero = '0;
  localparam logic signed [TurnWidth-1:0] TurnMinusOne = '1;

  localparam logic [AngleW-1:0] BoundQ1 = AngleW'(1024);
  localparam logic [AngleW-1:0] BoundQ2 = AngleW'(2048);
  localparam logic [AngleW-1:0] BoundQ3 = AngleW'(3072);

  localparam logic [QuadW-1:0] Quad1 = QuadW'(1);
  localparam logic [QuadW-1:0] Quad2 = QuadW'(2);
  localparam logic [QuadW-1:0] Quad3 = QuadW'(3);
  localparam logic [QuadW-1:0] Quad4 = QuadW'(4);

  localparam logic [CfgIdxW-1:0] RegAngleOffset = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegReverse     = CfgIdxW'(1);

  localparam logic ActTrack = 1'b0;
  localparam logic ActInit  = 1'b1;

  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic [QuadW-1:0]  quadrant;
  } mat_corr_t;

endpackage

FILE: sv/multi_turn_angle_tracker.sv
// Top level of the multi-turn angle tracker: channels, configuration and pipeline registers.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   action_i, raw_angle_i
//   out      output     out_valid_o / out_ready_i angle_o, quadrant_o, turn_count_o,
//                                                 total_angle_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls; a result is offered after its item has moved
// from the input register into the result register, which form the two stages; the turn
// state is updated as an item moves into the result register.
// Reset sets offset 0, forward direction, stored quadrant 1 and zero turns.
// A stalled output holds its result and stops the input stage once it is full.
`timescale 1ns / 1ps
module multi_turn_angle_tracker
  import mat_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [AngleW-1:0]          raw_angle_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [AngleW-1:0]          angle_o,
  output logic [QuadW-1:0]           quadrant_o,
  output logic signed [TurnCntW-1:0] turn_count_o,
  output logic signed [TotalW-1:0]   total_angle_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  logic [AngleW-1:0]           offset_q;
  logic                        reverse_q;
  logic                        s1_valid_q;
  logic                        s1_action_q;
  logic [AngleW-1:0]           s1_raw_q;
  logic                        out_valid_q;
  logic [AngleW-1:0]           angle_q;
  logic [QuadW-1:0]            quad_q;
  logic signed [TurnCntW-1:0]  turn_cnt_q;
  logic signed [TotalW-1:0]    total_q;
  logic                        advance;
  logic                        step;
  mat_corr_t                   corr;
  logic signed [TurnWidth-1:0] turns;
  logic signed [WideW-1:0]     wide_turns;
  logic signed [WideW-1:0]     wide_total;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign step        = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      reverse_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegAngleOffset: offset_q  <= cfg_data_i[AngleW-1:0];
        RegReverse:     reverse_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mat_correct u_correct (
    .raw_angle_i    (s1_raw_q),
    .angle_offset_i (offset_q),
    .reverse_i      (reverse_q),
    .corr_o         (corr)
  );

  mat_turns u_turns (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (step),
    .action_i (s1_action_q),
    .corr_i   (corr),
    .turns_o  (turns)
  );

  assign wide_turns = WideW'(turns);
  assign wide_total = (wide_turns <<< AngleW) | WideW'(corr.angle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_action_q <= action_i;
      s1_raw_q    <= raw_angle_i;
    end
    if (step) begin
      angle_q    <= corr.angle;
      quad_q     <= corr.quadrant;
      turn_cnt_q <= TurnCntW'(turns);
      total_q    <= wide_total[TotalW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign angle_o       = angle_q;
  assign quadrant_o    = quad_q;
  assign turn_count_o  = turn_cnt_q;
  assign total_angle_o = total_q;

endmodule

FILE: sv/mat_correct.sv
// Offset, direction correction and quadrant classification of one raw angle.
`timescale 1ns / 1ps
module mat_correct
  import mat_pkg::*;
(
  input  logic [AngleW-1:0] raw_angle_i,
  input  logic [AngleW-1:0] angle_offset_i,
  input  logic              reverse_i,
  output mat_corr_t         corr_o
);

  logic [AngleW-1:0] shifted;
  logic [AngleW-1:0] angle;

  assign shifted = raw_angle_i + angle_offset_i;
  assign angle   = reverse_i ? AngleW'(-shifted) : shifted;

  always_comb begin
    corr_o.angle = angle;
    if (angle <= BoundQ1) begin
      corr_o.quadrant = Quad1;
    end else if (angle <= BoundQ2) begin
      corr_o.quadrant = Quad2;
    end else if (angle <= BoundQ3) begin
      corr_o.quadrant = Quad3;
    end else begin
      corr_o.quadrant = Quad4;
    end
  end

endmodule

FILE: sv/mat_turns.sv
// Stored quadrant and saturating turn counter with their next-value logic.
`timescale 1ns / 1ps
module mat_turns
  import mat_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        action_i,
  input  mat_corr_t                   corr_i,
  output logic signed [TurnWidth-1:0] turns_o
);

  logic [QuadW-1:0]            last_quad_q;
  logic signed [TurnWidth-1:0] turns_q;
  logic signed [TurnWidth-1:0] turns_d;

  always_comb begin
    turns_d = turns_q;
    if (action_i == ActInit) begin
      turns_d = (corr_i.quadrant == Quad3 || corr_i.quadrant == Quad4) ? TurnMinusOne
                                                                        : TurnZero;
    end else if (corr_i.quadrant == Quad1 && last_quad_q == Quad4) begin
      if (turns_q != TurnMax) begin
        turns_d = turns_q + TurnWidth'(1);
      end
    end else if (corr_i.quadrant == Quad4 && last_quad_q == Quad1) begin
      if (turns_q != TurnMin) begin
        turns_d = turns_q - TurnWidth'(1);
      end
    end
  end

  assign turns_o = turns_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_quad_q <= Quad1;
      turns_q     <= TurnZero;
    end else if (en_i) begin
      last_quad_q <= corr_i.quadrant;
      turns_q     <= turns_d;
    end
  end

endmodule

FILE: sv/mat_checker.sv
// Port-level checker for the multi-turn angle tracker and its bind statement.
`timescale 1ns / 1ps
module mat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] angle_o,
  input logic [2:0]  quadrant_o,
  input logic [15:0] turn_count_o,
  input logic [28:0] total_angle_o
);

  // A stalled result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Input is taken when no result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i |-> in_ready_o)
    else $error("input refused with empty output stage");

  // Quadrant agrees with the corrected angle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((angle_o <= 12'd1024) == (quadrant_o == 3'd1)) &&
                    ((angle_o > 12'd3072) == (quadrant_o == 3'd4)))
    else $error("quadrant does not match angle");

  // Total angle is turns times a full turn plus the angle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_angle_o[11:0] == angle_o &&
                    total_angle_o[27:12] == turn_count_o &&
                    total_angle_o[28] == turn_count_o[15])
    else $error("total angle inconsistent");

endmodule

bind multi_turn_angle_tracker mat_checker u_mat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .angle_o       (angle_o),
  .quadrant_o    (quadrant_o),
  .turn_count_o  (turn_count_o),
  .total_angle_o (total_angle_o)
);
